// ===== hdl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg - calendar date stepper shared definitions
// Command and status codes, microcode format, control store and the
// calendar helper functions (leap year, month length).
// ----------------------------------------------------------------------------
package cds_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_CMP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ORD_EARLIER = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_LATER   = 2'd2
    } t_order;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_ACCEPT  = 3'd1,
        OP_ADD_DAY = 3'd2,
        OP_SUB_DAY = 3'd3,
        OP_LOAD    = 3'd4,
        OP_COMPARE = 3'd5,
        OP_EMIT    = 3'd6
    } t_op;

    // jump condition: taken -> target, else fall through to pc + 1
    typedef enum logic [3:0] {
        J_NEVER    = 4'd0,
        J_ALWAYS   = 4'd1,
        J_NO_INPUT = 4'd2,
        J_IS_CMP   = 4'd3,
        J_IS_LOAD  = 4'd4,
        J_IS_SUB   = 4'd5,
        J_ADD_MORE = 4'd6,
        J_SUB_MORE = 4'd7,
        J_OUT_BUSY = 4'd8
    } t_cond;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctl;

    // program addresses
    localparam t_pc PC_EMIT     = 4'd0;
    localparam t_pc PC_IDLE     = 4'd1;
    localparam t_pc PC_DISP_CMP = 4'd2;
    localparam t_pc PC_DISP_LD  = 4'd3;
    localparam t_pc PC_DISP_SUB = 4'd4;
    localparam t_pc PC_ADD      = 4'd5;
    localparam t_pc PC_ADD_END  = 4'd6;
    localparam t_pc PC_SUB      = 4'd7;
    localparam t_pc PC_SUB_END  = 4'd8;
    localparam t_pc PC_LOAD     = 4'd9;
    localparam t_pc PC_CMP      = 4'd10;

    localparam logic signed [15:0] YEAR_MAX = 16'sh7FFF;
    localparam logic signed [15:0] YEAR_MIN = -16'sh8000;

    // 25 * 23593 = 1 mod 2^16; a multiple of 25 maps to at most 65535 / 25
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_LIM = 16'd2621;

    // control store
    function automatic t_ctl ucode(input t_pc pc);
        t_ctl w;
        unique case (pc)
            PC_EMIT:     w = '{OP_EMIT,    J_OUT_BUSY, PC_EMIT};
            PC_IDLE:     w = '{OP_ACCEPT,  J_NO_INPUT, PC_IDLE};
            PC_DISP_CMP: w = '{OP_NOP,     J_IS_CMP,   PC_CMP};
            PC_DISP_LD:  w = '{OP_NOP,     J_IS_LOAD,  PC_LOAD};
            PC_DISP_SUB: w = '{OP_NOP,     J_IS_SUB,   PC_SUB};
            PC_ADD:      w = '{OP_ADD_DAY, J_ADD_MORE, PC_ADD};
            PC_ADD_END:  w = '{OP_NOP,     J_ALWAYS,   PC_EMIT};
            PC_SUB:      w = '{OP_SUB_DAY, J_SUB_MORE, PC_SUB};
            PC_SUB_END:  w = '{OP_NOP,     J_ALWAYS,   PC_EMIT};
            PC_LOAD:     w = '{OP_LOAD,    J_ALWAYS,   PC_EMIT};
            PC_CMP:      w = '{OP_COMPARE, J_ALWAYS,   PC_EMIT};
            default:     w = '{OP_NOP,     J_ALWAYS,   PC_IDLE};
        endcase
        return w;
    endfunction

    // |y| % 4 == 0 and (|y| % 25 != 0 or |y| % 16 == 0)
    function automatic logic leap_year(input logic signed [15:0] y);
        logic [15:0] a;
        logic [31:0] p;
        logic        div25;
        a     = y[15] ? 16'(-y) : 16'(y);
        p     = 32'(a) * 32'(INV25);
        div25 = (p[15:0] <= DIV25_LIM);
        return (a[1:0] == 2'd0) && (!div25 || (a[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/calendar_date_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper - Gregorian date register with day stepping
// Microcoded control store drives a small date datapath: load with check,
// step forward or back one day per cycle, compare against a given date.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction (tuser = command).
//   Master stream returns one result per command: the stored date after
//   the command, the compare order and a status code.
//   Path, accept to result valid: the accept step, the dispatch steps, the
//   load, compare or day-step microcode, then the emit step; the year limit
//   can end a day step early. Stepping runs one day per cycle in the ADD/SUB
//   microcode loop, so that loop sets the throughput; a new command is taken
//   only after the emit step of the last one.
//   s_axis_tready is high only while the sequencer sits in its idle step.
//   Results go to an output register: the next command can be accepted
//   and worked on while a result still waits for m_axis_tready; the emit
//   step holds until that register is free, so nothing is dropped.
//   Reset (synchronous, active low) sets the date to 1 January, year 1,
//   empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module calendar_date_stepper
    import cds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // day_in[4:0] month_in[8:5] year_in[24:9]
                                        // day_count[40:25], zero fill above
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // day_out[4:0] month_out[8:5] year_out[24:9]
                                        // order[26:25] status[28:27], zero fill above
);

    // sequencer
    t_pc  r_pc, n_pc;
    t_ctl ctl;
    logic jump;

    // latched command
    t_cmd               r_cmd, n_cmd;
    logic [4:0]         r_din, n_din;
    logic [3:0]         r_min, n_min;
    logic signed [15:0] r_yin, n_yin;
    logic [15:0]        r_cnt, n_cnt;

    // stored date and result
    logic [4:0]         r_day, n_day;
    logic [3:0]         r_month, n_month;
    logic signed [15:0] r_year, n_year;
    t_order             r_order, n_order;
    t_status            r_status, n_status;

    // leap flags of the stored and the loaded year, registered
    logic r_leap;       // leap flags, registered from their year
    logic r_lin;        // loaded year

    // output register
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_odata, n_odata;

    logic at_max, at_min, out_busy, load_ok;
    logic [4:0] cur_len, in_len, prev_len;
    logic [3:0] prev_month;

    assign ctl      = ucode(r_pc);
    assign out_busy = r_ovalid && !m_axis_tready;

    assign at_max = (r_year == YEAR_MAX) && (r_month == 4'd12) && (r_day == 5'd31);
    assign at_min = (r_year == YEAR_MIN) && (r_month == 4'd1) && (r_day == 5'd1);

    assign cur_len    = month_len(r_month, r_leap);
    assign prev_month = r_month - 4'd1;
    // leap flag is stale only right after a year change: step into Jan/Dec, or load
    assign prev_len   = month_len(prev_month, r_leap);
    assign in_len     = month_len(r_min, r_lin);
    assign load_ok    = (r_yin > 16'sd0) && (r_min >= 4'd1) && (r_min <= 4'd12)
                        && (r_din >= 5'd1) && (r_din <= in_len);

    // jump condition
    always_comb begin
        unique case (ctl.cond)
            J_NEVER:    jump = 1'b0;
            J_ALWAYS:   jump = 1'b1;
            J_NO_INPUT: jump = !s_axis_tvalid;
            J_IS_CMP:   jump = (r_cmd == CMD_CMP);
            J_IS_LOAD:  jump = (r_cmd == CMD_LOAD);
            J_IS_SUB:   jump = (r_cmd == CMD_SUB);
            J_ADD_MORE: jump = (r_cnt != 16'd0) && !at_max;
            J_SUB_MORE: jump = (r_cnt != 16'd0) && !at_min;
            J_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b0;
        endcase
    end

    assign n_pc = jump ? ctl.target : r_pc + t_pc'(1);

    // datapath
    always_comb begin
        n_cmd    = r_cmd;
        n_din    = r_din;
        n_min    = r_min;
        n_yin    = r_yin;
        n_cnt    = r_cnt;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_order  = r_order;
        n_status = r_status;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !m_axis_tready;

        unique case (ctl.op)
            OP_ACCEPT: begin
                n_cmd    = t_cmd'(s_axis_tuser);
                n_din    = s_axis_tdata[4:0];
                n_min    = s_axis_tdata[8:5];
                n_yin    = s_axis_tdata[24:9];
                n_cnt    = s_axis_tdata[40:25];
                n_order  = ORD_EARLIER;
                n_status = ST_OK;
            end
            OP_ADD_DAY: begin
                if (r_cnt != 16'd0) begin
                    if (at_max) begin
                        n_status = ST_LIMIT;
                    end else begin
                        n_cnt = r_cnt - 16'd1;
                        if (r_day == cur_len) begin
                            n_day = 5'd1;
                            if (r_month == 4'd12) begin
                                n_month = 4'd1;
                                n_year  = r_year + 16'sd1;
                            end else begin
                                n_month = r_month + 4'd1;
                            end
                        end else begin
                            n_day = r_day + 5'd1;
                        end
                    end
                end
            end
            OP_SUB_DAY: begin
                if (r_cnt != 16'd0) begin
                    if (at_min) begin
                        n_status = ST_LIMIT;
                    end else begin
                        n_cnt = r_cnt - 16'd1;
                        if (r_day == 5'd1) begin
                            if (r_month == 4'd1) begin
                                n_month = 4'd12;
                                n_year  = r_year - 16'sd1;
                                n_day   = 5'd31;
                            end else begin
                                n_month = prev_month;
                                n_day   = prev_len;
                            end
                        end else begin
                            n_day = r_day - 5'd1;
                        end
                    end
                end
            end
            OP_LOAD: begin
                if (load_ok) begin
                    n_day   = r_din;
                    n_month = r_min;
                    n_year  = r_yin;
                end else begin
                    n_status = ST_INVALID;
                end
            end
            OP_COMPARE: begin
                if (r_year != r_yin) begin
                    n_order = (r_year < r_yin) ? ORD_EARLIER : ORD_LATER;
                end else if (r_month != r_min) begin
                    n_order = (r_month < r_min) ? ORD_EARLIER : ORD_LATER;
                end else if (r_day != r_din) begin
                    n_order = (r_day < r_din) ? ORD_EARLIER : ORD_LATER;
                end else begin
                    n_order = ORD_EQUAL;
                end
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    n_ovalid = 1'b1;
                    n_odata  = {3'd0, r_status, r_order, r_year, r_month, r_day};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_IDLE;
            r_ovalid <= 1'b0;
            r_day    <= 5'd1;
            r_month  <= 4'd1;
            r_year   <= 16'sd1;
        end else begin
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_din    <= n_din;
        r_min    <= n_min;
        r_yin    <= n_yin;
        r_cnt    <= n_cnt;
        r_order  <= n_order;
        r_status <= n_status;
        r_odata  <= n_odata;
        r_leap   <= leap_year(r_year);
        r_lin    <= leap_year(r_yin);
    end

    assign s_axis_tready = (ctl.op == OP_ACCEPT);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule
